### rtl/core/scaled_matrix_multiply_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaled matrix multiply unit
// Shared property forms with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef SCALED_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define SCALED_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared widths, codes, command struct and helpers of the matrix multiply unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smm_pkg;

	// Field widths
	localparam int ELEM_W     = 16;
	localparam int ROW_W      = 3;
	localparam int ACT_W      = 2;
	localparam int DIM_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Parameter defaults
	localparam int MAX_DIM_DEF   = 8;
	localparam int FRAC_BITS_DEF = 12;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE_C = 2'd2;
	localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd4;

	// Configuration reset values
	localparam logic [DIM_W-1:0]         DIM_RST   = 4'd8;
	localparam logic signed [ELEM_W-1:0] ALPHA_RST = 16'sd4096;
	localparam logic signed [ELEM_W-1:0] BETA_RST  = 16'sd0;

	// Controller to datapath command
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             wr_c;
		logic             rd_en;
		logic             acc_first;
		logic             mix_en;
		logic             out_load;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [ROW_W-1:0] step;
	} smm_cmd_t;

	// Clamp a dimension register to 1..max_dim and return its last index
	function automatic logic [ROW_W-1:0] dim_last(input logic [DIM_W-1:0] d,
		input int max_dim);
		logic [ROW_W-1:0] res;
		if (d == '0) begin
			res = '0;
		end else if (int'(d) > max_dim) begin
			res = ROW_W'(max_dim - 1);
		end else begin
			res = ROW_W'(int'(d) - 1);
		end
		return res;
	endfunction

endpackage

### rtl/core/smm_ram.sv
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/smm_ctrl.sv
// ----------------------------------------------------------------------------
// smm_ctrl
// Sequencer: takes input beats, walks rows, columns and the inner index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_ctrl #(
	parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [smm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic [smm_pkg::ACT_W-1:0]      action,
	input  logic [smm_pkg::ROW_W-1:0]      row_index,
	input  logic [smm_pkg::ROW_W-1:0]      col_index,
	input  logic                           out_stall,
	output logic                           in_stall,
	output logic                           out_valid,
	output smm_pkg::smm_cmd_t              cmd
);

	import smm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DRAIN1,
		S_DRAIN2,
		S_MIX,
		S_SAT
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] rows_m_q;
	logic [DIM_W-1:0] cols_n_q;
	logic [DIM_W-1:0] inner_k_q;
	logic [ROW_W-1:0] i_q;
	logic [ROW_W-1:0] j_q;
	logic [ROW_W-1:0] t_q;
	logic             out_valid_q;

	logic [ROW_W-1:0] m_last;
	logic [ROW_W-1:0] n_last;
	logic [ROW_W-1:0] k_last;
	logic             accept;
	logic             in_range;
	logic             slot_free;
	logic             elem_last;

	// Dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= DIM_RST;
			cols_n_q  <= DIM_RST;
			inner_k_q <= DIM_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ROWS_M:  rows_m_q  <= cfg_data[DIM_W-1:0];
				CFG_COLS_N:  cols_n_q  <= cfg_data[DIM_W-1:0];
				CFG_INNER_K: inner_k_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped loop bounds and handshake terms
	assign m_last    = dim_last(rows_m_q, MAX_DIM);
	assign n_last    = dim_last(cols_n_q, MAX_DIM);
	assign k_last    = dim_last(inner_k_q, MAX_DIM);
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_range  = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign slot_free = !out_valid_q || !out_stall;
	assign elem_last = (i_q == m_last) && (j_q == n_last);
	assign out_valid = out_valid_q;

	// State, loop counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on a loaded beat, drop it once taken
			if (state_q == S_SAT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && action == ACT_COMPUTE) begin
						i_q     <= '0;
						j_q     <= '0;
						t_q     <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (t_q == k_last) begin
						t_q     <= '0;
						state_q <= S_DRAIN1;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_DRAIN1: state_q <= S_DRAIN2;
				S_DRAIN2: state_q <= S_MIX;
				S_MIX:    state_q <= S_SAT;
				S_SAT: begin
					if (slot_free) begin
						if (elem_last) begin
							state_q <= S_IDLE;
						end else begin
							if (j_q == n_last) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command to the datapath
	always_comb begin
		cmd           = '0;
		cmd.wr_a      = accept && in_range && (action == ACT_WRITE_A);
		cmd.wr_b      = accept && in_range && (action == ACT_WRITE_B);
		cmd.wr_c      = accept && in_range && (action == ACT_WRITE_C);
		cmd.rd_en     = (state_q == S_READ);
		cmd.acc_first = (t_q == '0);
		cmd.mix_en    = (state_q == S_MIX);
		cmd.out_load  = (state_q == S_SAT) && slot_free;
		cmd.last      = elem_last;
		cmd.row       = i_q;
		cmd.col       = j_q;
		cmd.step      = t_q;
	end

endmodule

### rtl/core/smm_datapath.sv
// ----------------------------------------------------------------------------
// smm_datapath
// Element stores, multiply-accumulate, alpha/beta mix, saturation, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smm_datapath #(
	parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = smm_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [smm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  smm_pkg::smm_cmd_t                 cmd,
	input  logic [smm_pkg::ROW_W-1:0]         row_index,
	input  logic [smm_pkg::ROW_W-1:0]         col_index,
	input  logic signed [smm_pkg::ELEM_W-1:0] element_value,
	output logic [smm_pkg::ROW_W-1:0]         out_row,
	output logic [smm_pkg::ROW_W-1:0]         out_col,
	output logic signed [smm_pkg::ELEM_W-1:0] out_value,
	output logic                              is_last
);

	import smm_pkg::*;

	localparam int CELLS  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = PROD_W + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
	localparam int DOT_W  = ACC_W - FRAC_BITS;
	localparam int AP_W   = ELEM_W + DOT_W;
	localparam int MIX_W  = AP_W + 1;
	localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'(2 ** (ELEM_W - 1) - 1);
	localparam logic signed [MIX_W-1:0] SAT_LO = -MIX_W'(2 ** (ELEM_W - 1));

	logic signed [ELEM_W-1:0] alpha_q;
	logic signed [ELEM_W-1:0] beta_q;

	logic [ELEM_W-1:0]        a_rdata;
	logic [ELEM_W-1:0]        b_rdata;
	logic [ELEM_W-1:0]        c_rdata;
	logic                     c_we;
	logic [ADDR_W-1:0]        c_waddr;
	logic [ELEM_W-1:0]        c_wdata;
	logic [ADDR_W-1:0]        wr_addr;

	logic                     vld_s1;
	logic                     first_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic                     first_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DOT_W-1:0]  dot;
	logic signed [AP_W-1:0]   alpha_prod_q;
	logic signed [PROD_W-1:0] beta_prod_q;
	logic signed [MIX_W-1:0]  mix_sum;
	logic signed [MIX_W-1:0]  mix_sh;
	logic signed [ELEM_W-1:0] sat_val;

	logic [ROW_W-1:0]         out_row_q;
	logic [ROW_W-1:0]         out_col_q;
	logic signed [ELEM_W-1:0] out_value_q;
	logic                     is_last_q;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [ROW_W-1:0] c);
		return ADDR_W'(int'(r) * MAX_DIM + int'(c));
	endfunction

	// Scale registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ALPHA: alpha_q <= cfg_data[ELEM_W-1:0];
				CFG_BETA:  beta_q  <= cfg_data[ELEM_W-1:0];
				default: ;
			endcase
		end
	end

	// Stores: A and B take input beats, C also takes the write-back
	assign wr_addr = cell_addr(row_index, col_index);
	assign c_we    = cmd.wr_c || cmd.out_load;
	assign c_waddr = cmd.out_load ? cell_addr(cmd.row, cmd.col) : wr_addr;
	assign c_wdata = cmd.out_load ? sat_val : element_value;

	smm_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (wr_addr),
		.wdata (element_value),
		.re    (cmd.rd_en),
		.raddr (cell_addr(cmd.row, cmd.step)),
		.rdata (a_rdata)
	);

	smm_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (wr_addr),
		.wdata (element_value),
		.re    (cmd.rd_en),
		.raddr (cell_addr(cmd.step, cmd.col)),
		.rdata (b_rdata)
	);

	smm_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_c (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (cmd.rd_en && cmd.acc_first),
		.raddr (cell_addr(cmd.row, cmd.col)),
		.rdata (c_rdata)
	);

	// Track read and product beats through the MAC pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd_en;
			first_s1 <= cmd.acc_first;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
		end
	end

	// Multiply one A and B pair
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
		end
	end

	// Accumulate the exact dot product, restart on the first step
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign dot = DOT_W'(acc_q >>> FRAC_BITS);

	// Scale the dot product and the old C element
	always_ff @(posedge clk) begin
		if (cmd.mix_en) begin
			alpha_prod_q <= alpha_q * dot;
			beta_prod_q  <= beta_q * $signed(c_rdata);
		end
	end

	// Combine, shift and saturate
	assign mix_sum = MIX_W'(alpha_prod_q) + MIX_W'(beta_prod_q);
	assign mix_sh  = mix_sum >>> FRAC_BITS;

	always_comb begin
		if (mix_sh > SAT_HI) begin
			sat_val = ELEM_W'(SAT_HI);
		end else if (mix_sh < SAT_LO) begin
			sat_val = ELEM_W'(SAT_LO);
		end else begin
			sat_val = ELEM_W'(mix_sh);
		end
	end

	// Output beat register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_row_q   <= cmd.row;
			out_col_q   <= cmd.col;
			out_value_q <= sat_val;
			is_last_q   <= cmd.last;
		end
	end

	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign is_last   = is_last_q;

endmodule

### rtl/core/scaled_matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_unit
// C = alpha*A*B + beta*C over on-chip A, B and C stores of signed Q4.12.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | action, row_index, col_index, element_value
//   out     | output    | out_valid/out_stall | out_row, out_col, out_value, is_last
//   cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// A compute beat emits m*n results; each passes through k reads on the
// single shared multiply-accumulate, the pipe drain states, the scale
// multiply and the saturate stage. Output stall holds the run at the
// saturate stage. Reset clears control and config only; the stores are
// not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaled_matrix_multiply_unit #(
	parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = smm_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [smm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [smm_pkg::ACT_W-1:0]         action,
	input  logic [smm_pkg::ROW_W-1:0]         row_index,
	input  logic [smm_pkg::ROW_W-1:0]         col_index,
	input  logic signed [smm_pkg::ELEM_W-1:0] element_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [smm_pkg::ROW_W-1:0]         out_row,
	output logic [smm_pkg::ROW_W-1:0]         out_col,
	output logic signed [smm_pkg::ELEM_W-1:0] out_value,
	output logic                              is_last
);

	import smm_pkg::*;

	smm_cmd_t cmd;

	// Sequencer
	smm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.action    (action),
		.row_index (row_index),
		.col_index (col_index),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Stores and arithmetic
	smm_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.out_value     (out_value),
		.is_last       (is_last)
	);

endmodule

### rtl/core/smm_checker.sv
// ----------------------------------------------------------------------------
// smm_checker
// Port-level checks of the matrix multiply unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scaled_matrix_multiply_unit_assert.svh"

module smm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [smm_pkg::ACT_W-1:0]         action,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [smm_pkg::ROW_W-1:0]         out_row,
	input logic [smm_pkg::ROW_W-1:0]         out_col,
	input logic signed [smm_pkg::ELEM_W-1:0] out_value,
	input logic                              is_last
);

	import smm_pkg::*;

	// Hold a stalled output beat
	`SMM_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid, "out_valid dropped under stall")
	`SMM_ASSERT_NEXT(a_out_data_hold, out_valid && out_stall, $stable(out_row) && $stable(out_col) && $stable(out_value) && $stable(is_last), "output beat changed under stall")

	// A compute beat starts a run that blocks the input
	`SMM_ASSERT_NEXT(a_compute_blocks, in_valid && !in_stall && action == ACT_COMPUTE, in_stall, "input open after compute beat")

	// A write beat keeps the input open
	`SMM_ASSERT_NEXT(a_write_open, in_valid && !in_stall && action != ACT_COMPUTE, !in_stall, "input stalled after write beat")

endmodule

bind scaled_matrix_multiply_unit smm_checker u_smm_checker (.*);

### dv/scaled_matrix_multiply_unit_test.sv
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_unit_test
// Loads A, B and C element by element, runs scaled multiply passes over a
// range of shapes and scales, and compares every emitted C element against
// a shadow copy of the stores that computes the same fixed-point result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaled_matrix_multiply_unit_test;

	import smm_pkg::*;

	localparam int SIDE         = MAX_DIM_DEF;
	localparam int FRAC         = FRAC_BITS_DEF;
	localparam int RANDOM_ITEMS = 120;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = SIDE + 8;
	localparam int TAIL         = 2 * (SIDE + 4) + 8;
	localparam int REPORT_MAX   = 10;

	// One emitted C element
	typedef struct {
		logic [ROW_W-1:0]         row;
		logic [ROW_W-1:0]         col;
		logic signed [ELEM_W-1:0] value;
		logic                     last;
	} c_elem_t;

	// Shadow of the three stores and the registers; yields the expected elements
	class gemm_shadow;
		logic signed [ELEM_W-1:0] a_store[SIDE*SIDE];
		logic signed [ELEM_W-1:0] b_store[SIDE*SIDE];
		logic signed [ELEM_W-1:0] c_store[SIDE*SIDE];
		bit                       written[3][SIDE*SIDE];
		logic [DIM_W-1:0]         rows_m;
		logic [DIM_W-1:0]         cols_n;
		logic [DIM_W-1:0]         inner_k;
		logic signed [ELEM_W-1:0] alpha;
		logic signed [ELEM_W-1:0] beta;
		c_elem_t                  due_elems[$];
		int                       mismatches;

		function new();
			rows_m     = DIM_RST;
			cols_n     = DIM_RST;
			inner_k    = DIM_RST;
			alpha      = ALPHA_RST;
			beta       = BETA_RST;
			mismatches = 0;
		endfunction

		// Dimension register as the block uses it: 0 acts as 1, above SIDE as SIDE
		function int span(logic [DIM_W-1:0] d);
			if (d == '0) begin
				return 1;
			end
			if (int'(d) > SIDE) begin
				return SIDE;
			end
			return int'(d);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ROWS_M: begin
					rows_m = data[DIM_W-1:0];
				end
				CFG_COLS_N: begin
					cols_n = data[DIM_W-1:0];
				end
				CFG_INNER_K: begin
					inner_k = data[DIM_W-1:0];
				end
				CFG_ALPHA: begin
					alpha = data;
				end
				CFG_BETA: begin
					beta = data;
				end
				default: begin
				end
			endcase
		endfunction

		// Exact dot product, rescale, alpha/beta blend, rescale and saturate
		function logic signed [ELEM_W-1:0] blend_element(int i, int j, int k);
			longint acc;
			longint dot;
			longint mix;
			acc = 0;
			for (int t = 0; t < k; t++) begin
				acc += longint'(a_store[i*SIDE+t]) * longint'(b_store[t*SIDE+j]);
			end
			dot = acc >>> FRAC;
			mix = (longint'(alpha) * dot + longint'(beta) * longint'(c_store[i*SIDE+j])) >>> FRAC;
			if (mix > 32767) begin
				mix = 32767;
			end
			if (mix < -32768) begin
				mix = -32768;
			end
			return ELEM_W'(mix);
		endfunction

		// Apply one accepted input beat
		function void take_beat(logic [ACT_W-1:0] act, logic [ROW_W-1:0] r,
			logic [ROW_W-1:0] c, logic signed [ELEM_W-1:0] v);
			int      m;
			int      n;
			int      k;
			c_elem_t e;
			case (act)
				ACT_WRITE_A: begin
					a_store[r*SIDE+c] = v;
				end
				ACT_WRITE_B: begin
					b_store[r*SIDE+c] = v;
				end
				ACT_WRITE_C: begin
					c_store[r*SIDE+c] = v;
				end
				default: begin
					m = span(rows_m);
					n = span(cols_n);
					k = span(inner_k);
					for (int i = 0; i < m; i++) begin
						for (int j = 0; j < n; j++) begin
							e.row   = ROW_W'(i);
							e.col   = ROW_W'(j);
							e.value = blend_element(i, j, k);
							e.last  = (i == m - 1) && (j == n - 1);
							c_store[i*SIDE+j] = e.value;
							due_elems.push_back(e);
						end
					end
				end
			endcase
			if (act != ACT_COMPUTE) begin
				written[act][r*SIDE+c] = 1'b1;
			end
		endfunction

		// Compare one accepted output beat with the oldest pending element
		function void match_element(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c,
			logic signed [ELEM_W-1:0] v, logic l);
			c_elem_t e;
			if (due_elems.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: element with none pending: row %0d col %0d value %0d last %0b",
						$realtime, r, c, v, l);
				end
				return;
			end
			e = due_elems.pop_front();
			if (r !== e.row || c !== e.col || v !== e.value || l !== e.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: element mismatch: expected row %0d col %0d value %0d last %0b, got row %0d col %0d value %0d last %0b",
						$realtime, e.row, e.col, e.value, e.last, r, c, v, l);
				end
			end
		endfunction

		function int outstanding();
			return due_elems.size();
		endfunction

		function int failures();
			return mismatches + due_elems.size();
		endfunction
	endclass

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     cfg_write     = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index     = '0;
	logic [CFG_DATA_W-1:0]    cfg_data      = '0;
	logic                     in_valid      = 1'b0;
	logic                     in_stall;
	logic [ACT_W-1:0]         action        = ACT_WRITE_A;
	logic [ROW_W-1:0]         row_index     = '0;
	logic [ROW_W-1:0]         col_index     = '0;
	logic signed [ELEM_W-1:0] element_value = '0;
	logic                     out_valid;
	logic                     out_stall     = 1'b0;
	logic [ROW_W-1:0]         out_row;
	logic [ROW_W-1:0]         out_col;
	logic signed [ELEM_W-1:0] out_value;
	logic                     is_last;

	logic       long_hold_go  = 1'b0;
	int         send_idle_pct = 35;
	int         recv_idle_pct = 47;
	int         sent_beats    = 0;
	gemm_shadow shadow        = new();

	scaled_matrix_multiply_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.row_index    (row_index),
		.col_index    (col_index),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.is_last      (is_last)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Element value, often one of the corner values
	function automatic logic [ELEM_W-1:0] pick_elem();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// Scale value: corners, unity, small or anything
	function automatic logic [ELEM_W-1:0] pick_scale();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h1000;
			4, 5: return ELEM_W'(int'($urandom_range(8191)) - 4096);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// Dimension: mostly small, sometimes zero, mid-size or above the maximum
	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(9))
			7: return '0;
			8: return DIM_W'($urandom_range(SIDE, 4));
			9: return DIM_W'($urandom_range(15, SIDE + 1));
			default: return DIM_W'($urandom_range(3, 1));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		shadow.set_register(idx, data);
	endtask

	// Write every register; dimension writes carry random upper bits
	task automatic program_regs(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n,
		input logic [DIM_W-1:0] k, input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
		write_reg(CFG_ROWS_M, {12'($urandom), m});
		write_reg(CFG_COLS_N, {12'($urandom), n});
		write_reg(CFG_INNER_K, {12'($urandom), k});
		write_reg(CFG_ALPHA, a);
		write_reg(CFG_BETA, b);
		// unused index, must be ignored
		if ($urandom_range(1) == 1) begin
			write_reg(CFG_IDX_W'($urandom_range({CFG_IDX_W{1'b1}}, CFG_BETA + 1)),
				CFG_DATA_W'($urandom));
		end
		cfg_write <= 1'b0;
	endtask

	// Offer one beat after a random gap and hold it until taken
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [ROW_W-1:0] r,
		input logic [ROW_W-1:0] c, input logic [ELEM_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		row_index     <= r;
		col_index     <= c;
		element_value <= v;
		do @(posedge clk); while (in_stall);
		shadow.take_beat(act, r, c, v);
		sent_beats++;
	endtask

	task automatic send_random_write();
		logic [ACT_W-1:0] act;
		int               lim;
		act = ACT_W'($urandom_range(ACT_WRITE_C, ACT_WRITE_A));
		lim = ($urandom_range(1) == 1) ? 3 : SIDE - 1;
		send_item(act, ROW_W'($urandom_range(lim)), ROW_W'($urandom_range(lim)), pick_elem());
	endtask

	// Fill any entry the pass will read that was never loaded, then start the pass
	task automatic run_compute();
		int m;
		int n;
		int k;
		m = shadow.span(shadow.rows_m);
		n = shadow.span(shadow.cols_n);
		k = shadow.span(shadow.inner_k);
		for (int i = 0; i < m; i++) begin
			for (int t = 0; t < k; t++) begin
				if (!shadow.written[ACT_WRITE_A][i*SIDE+t]) begin
					send_item(ACT_WRITE_A, ROW_W'(i), ROW_W'(t), pick_elem());
				end
			end
		end
		for (int t = 0; t < k; t++) begin
			for (int j = 0; j < n; j++) begin
				if (!shadow.written[ACT_WRITE_B][t*SIDE+j]) begin
					send_item(ACT_WRITE_B, ROW_W'(t), ROW_W'(j), pick_elem());
				end
			end
		end
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				if (!shadow.written[ACT_WRITE_C][i*SIDE+j]) begin
					send_item(ACT_WRITE_C, ROW_W'(i), ROW_W'(j), pick_elem());
				end
			end
		end
		send_item(ACT_COMPUTE, ROW_W'($urandom), ROW_W'($urandom), ELEM_W'($urandom));
	endtask

	// Drop valid, wait for every pending element, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (shadow.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// Output side: take beats, stall at random, honor one long hold-off
	initial begin : result_side
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				shadow.match_element(out_row, out_col, out_value, is_last);
			end
			if (long_hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int phase;
		int burst;
		phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner operands with corner scales: both saturation directions
		program_regs(4'd2, 4'd2, 4'd2, 16'h7FFF, 16'h8000);
		send_item(ACT_WRITE_A, 3'd0, 3'd0, 16'h8000);
		send_item(ACT_WRITE_A, 3'd0, 3'd1, 16'h8000);
		send_item(ACT_WRITE_A, 3'd1, 3'd0, 16'h7FFF);
		send_item(ACT_WRITE_A, 3'd1, 3'd1, 16'hFFFF);
		send_item(ACT_WRITE_B, 3'd0, 3'd0, 16'h8000);
		send_item(ACT_WRITE_B, 3'd1, 3'd0, 16'h8000);
		send_item(ACT_WRITE_B, 3'd0, 3'd1, 16'h7FFF);
		send_item(ACT_WRITE_B, 3'd1, 3'd1, 16'h0000);
		send_item(ACT_WRITE_C, 3'd0, 3'd0, 16'h7FFF);
		send_item(ACT_WRITE_C, 3'd0, 3'd1, 16'h8000);
		send_item(ACT_WRITE_C, 3'd1, 3'd0, 16'h0000);
		send_item(ACT_WRITE_C, 3'd1, 3'd1, 16'h0001);
		// far corners with alternating bit patterns
		send_item(ACT_WRITE_A, 3'd7, 3'd7, 16'h5555);
		send_item(ACT_WRITE_B, 3'd7, 3'd0, 16'hAAAA);
		send_item(ACT_WRITE_C, 3'd0, 3'd7, 16'hAAAA);
		// compute beats ignore their other fields; second pass reuses written-back C
		send_item(ACT_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
		settle();

		// zero dimensions act as one
		program_regs(4'd0, 4'd0, 4'd0, 16'h8000, 16'h7FFF);
		send_item(ACT_COMPUTE, 3'd5, 3'd2, 16'h1234);
		send_item(ACT_WRITE_C, 3'd0, 3'd0, 16'h8000);
		send_item(ACT_COMPUTE, 3'd2, 3'd5, 16'hEDCB);

		// random phases: receiver then sender idles harder, then no idling
		while (phase < 3 || sent_beats < RANDOM_ITEMS) begin
			settle();
			if (phase == 0) begin
				send_idle_pct = 35;
				recv_idle_pct = 47;
			end else if (phase == 1) begin
				send_idle_pct = 47;
				recv_idle_pct = 35;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase == 0) begin
				program_regs(4'd3, 4'd3, 4'd2, pick_scale(), pick_scale());
			end else if (phase == 2) begin
				program_regs(4'd15, 4'd2, 4'd1, 16'h1000, 16'h0800);
			end else begin
				program_regs(pick_dim(), pick_dim(), pick_dim(), pick_scale(), pick_scale());
			end

			// hold the output long while beats keep coming, so input backs up
			if (phase == 0) begin
				long_hold_go <= 1'b1;
				run_compute();
				repeat (6) send_random_write();
				run_compute();
			end

			burst = $urandom_range(16, 8);
			repeat (burst) begin
				if ($urandom_range(4) == 0) begin
					run_compute();
				end else begin
					send_random_write();
				end
			end
			run_compute();
			phase++;
		end

		settle();
		repeat (TAIL) @(posedge clk);
		if (shadow.failures() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hang guard
	initial begin : watchdog
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
